[rtl/core/gbet_pkg.sv]
// ----------------------------------------------------------------------------
// gbet_pkg
// Shared types and codes for the bridge edge tester.
// ----------------------------------------------------------------------------
package gbet_pkg;

    localparam int VTX_W = 6;   // vertex number field
    localparam int CNT_W = 7;   // vertex count and reach counts
    localparam int ST_W  = 3;   // result status

    localparam logic [ST_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [ST_W-1:0] ST_RANGE      = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_EDGE   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_BRIDGE = 3'd3;
    localparam logic [ST_W-1:0] ST_BRIDGE     = 3'd4;

    // row read address source
    typedef enum logic [1:0] {
        RD_A    = 2'd0,
        RD_B    = 2'd1,
        RD_PICK = 2'd2
    } t_rd_sel;

    // controller -> datapath
    typedef struct packed {
        logic            latch;      // capture request fields
        logic            rd_en;      // row read
        t_rd_sel         rd_sel;
        logic            wr_en;      // row write: last row read, plus one edge bit
        logic            wr_b;       // 0: row a gets bit b, 1: row b gets bit a
        logic            init;       // start a walk
        logic            init_b;     // walk from b with the edge hidden
        logic            pick;       // expand one pending vertex
        logic            merge;      // fold its row into the visited set
        logic            save_with;  // keep the first count
        logic            load_out;   // fill the result register
        logic [ST_W-1:0] out_status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bad;          // a vertex at or above the live count
        logic mode;
        logic pending_any;  // visited vertices not yet expanded
        logic adj;          // edge a-b present
        logic cnt_equal;    // second count equals the first
    } t_dp_stat;

endpackage

[rtl/core/gbet_ram.sv]
// ----------------------------------------------------------------------------
// gbet_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/gbet_datapath.sv]
// ----------------------------------------------------------------------------
// gbet_datapath
// Adjacency store, walk registers (visited / expanded sets), counters,
// vertex count register and the result register.
// ----------------------------------------------------------------------------
module gbet_datapath #(
    parameter int MAX_NODES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gbet_pkg::t_cmd               i_cmd,
    output gbet_pkg::t_dp_stat           o_stat,
    input  logic                         i_cfg_we,
    input  logic [gbet_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_mode,
    input  logic [gbet_pkg::VTX_W-1:0]   i_vertex_a,
    input  logic [gbet_pkg::VTX_W-1:0]   i_vertex_b,
    output logic [gbet_pkg::ST_W-1:0]    o_status,
    output logic [gbet_pkg::CNT_W-1:0]   o_reach_with_edge,
    output logic [gbet_pkg::CNT_W-1:0]   o_reach_without_edge
);

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [MAX_NODES-1:0] BIT0 = {{(MAX_NODES-1){1'b0}}, 1'b1};

    logic [gbet_pkg::CNT_W-1:0] r_vertex_count;
    logic                       r_mode;
    logic                       r_bad;
    logic [gbet_pkg::VTX_W-1:0] r_a;
    logic [gbet_pkg::VTX_W-1:0] r_b;
    logic                       n_bad;

    logic [MAX_NODES-1:0]       r_row_vld;
    logic                       r_rd_vld;
    logic [MAX_NODES-1:0]       ram_q;
    logic [MAX_NODES-1:0]       row;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [MAX_NODES-1:0]       wr_data;

    logic [MAX_NODES-1:0]       r_visited;
    logic [MAX_NODES-1:0]       r_expanded;
    logic [MAX_NODES-1:0]       pending;
    logic [MAX_NODES-1:0]       live_mask;
    logic [MAX_NODES-1:0]       hide_mask;
    logic [AW-1:0]              pick_idx;
    logic [AW-1:0]              r_here;
    logic                       r_hide;
    logic                       r_adj;
    logic [gbet_pkg::CNT_W-1:0] r_cnt;
    logic [gbet_pkg::CNT_W-1:0] r_with;

    logic [gbet_pkg::ST_W-1:0]  r_out_status;
    logic [gbet_pkg::CNT_W-1:0] r_out_with;
    logic [gbet_pkg::CNT_W-1:0] r_out_without;

    logic [AW-1:0]              a_idx;
    logic [AW-1:0]              b_idx;
    logic [MAX_NODES-1:0]       a_bit;
    logic [MAX_NODES-1:0]       b_bit;

    assign a_idx = AW'(r_a);
    assign b_idx = AW'(r_b);
    assign a_bit = BIT0 << a_idx;
    assign b_bit = BIT0 << b_idx;

    // live count saturates at MAX_NODES
    always_comb begin
        int n_eff;
        n_eff = (int'(r_vertex_count) > MAX_NODES) ? MAX_NODES : int'(r_vertex_count);
        n_bad = (int'(i_vertex_a) >= n_eff) || (int'(i_vertex_b) >= n_eff);
        for (int i = 0; i < MAX_NODES; i++) begin
            live_mask[i] = (i < n_eff);
        end
    end

    // rows never written read as empty
    assign row = r_rd_vld ? ram_q : '0;

    always_comb begin
        case (i_cmd.rd_sel)
            gbet_pkg::RD_A:    rd_addr = a_idx;
            gbet_pkg::RD_B:    rd_addr = b_idx;
            gbet_pkg::RD_PICK: rd_addr = pick_idx;
            default:           rd_addr = a_idx;
        endcase
    end

    assign wr_addr = i_cmd.wr_b ? b_idx : a_idx;
    assign wr_data = row | (i_cmd.wr_b ? a_bit : b_bit);

    gbet_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    assign pending = r_visited & ~r_expanded;

    // lowest pending vertex
    always_comb begin
        pick_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (pending[i]) begin
                pick_idx = AW'(i);
            end
        end
    end

    // edge a-b masked out of both its rows during the second walk
    always_comb begin
        hide_mask = '0;
        if (r_hide && r_here == a_idx) begin
            hide_mask = hide_mask | b_bit;
        end
        if (r_hide && r_here == b_idx) begin
            hide_mask = hide_mask | a_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_row_vld      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_data;
            end
            if (i_cmd.wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_a    <= i_vertex_a;
            r_b    <= i_vertex_b;
            r_bad  <= n_bad;
        end
        if (i_cmd.rd_en) begin
            r_rd_vld <= r_row_vld[rd_addr];
        end
        if (i_cmd.init) begin
            r_visited  <= i_cmd.init_b ? b_bit : a_bit;
            r_expanded <= '0;
            r_cnt      <= '0;
            r_hide     <= i_cmd.init_b;
        end
        if (i_cmd.pick) begin
            r_expanded <= r_expanded | (BIT0 << pick_idx);
            r_cnt      <= r_cnt + 1'b1;
            r_here     <= pick_idx;
        end
        if (i_cmd.merge) begin
            r_visited <= r_visited | (row & live_mask & ~hide_mask);
            if (!r_hide && r_here == a_idx) begin
                r_adj <= row[b_idx];
            end
        end
        if (i_cmd.save_with) begin
            r_with <= r_cnt;
        end
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            case (i_cmd.out_status) inside
                gbet_pkg::ST_NOT_EDGE: begin
                    r_out_with    <= r_with;
                    r_out_without <= '0;
                end
                gbet_pkg::ST_NOT_BRIDGE, gbet_pkg::ST_BRIDGE: begin
                    r_out_with    <= r_with;
                    r_out_without <= r_cnt;
                end
                default: begin
                    r_out_with    <= '0;
                    r_out_without <= '0;
                end
            endcase
        end
    end

    assign o_stat.bad         = r_bad;
    assign o_stat.mode        = r_mode;
    assign o_stat.pending_any = |pending;
    assign o_stat.adj         = r_adj;
    assign o_stat.cnt_equal   = (r_cnt == r_with);

    assign o_status             = r_out_status;
    assign o_reach_with_edge    = r_out_with;
    assign o_reach_without_edge = r_out_without;

endmodule

[rtl/core/gbet_ctrl.sv]
// ----------------------------------------------------------------------------
// gbet_ctrl
// Sequencer: decode, insert read-modify-write, the two walks, result hand-off.
// ----------------------------------------------------------------------------
module gbet_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  gbet_pkg::t_dp_stat i_stat,
    output gbet_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD_A,
        S_INS_WR_A,
        S_INS_RD_B,
        S_INS_WR_B,
        S_PICK,
        S_MERGE,
        S_FINISH
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_phase;     // 0: walk from a, 1: walk from b
    logic                      n_phase;
    logic [gbet_pkg::ST_W-1:0] r_status;
    logic [gbet_pkg::ST_W-1:0] n_status;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = gbet_pkg::RD_A;
        o_cmd.out_status = r_status;
        n_state          = r_state;
        n_phase          = r_phase;
        n_status         = r_status;
        n_out_valid      = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.bad) begin
                    n_status = gbet_pkg::ST_RANGE;
                    n_state  = S_FINISH;
                end else if (!i_stat.mode) begin
                    n_state = S_INS_RD_A;
                end else begin
                    o_cmd.init = 1'b1;
                    n_phase    = 1'b0;
                    n_state    = S_PICK;
                end
            end
            S_INS_RD_A: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = gbet_pkg::RD_A;
                n_state      = S_INS_WR_A;
            end
            S_INS_WR_A: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_INS_RD_B;
            end
            S_INS_RD_B: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = gbet_pkg::RD_B;
                n_state      = S_INS_WR_B;
            end
            S_INS_WR_B: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_b  = 1'b1;
                n_status    = gbet_pkg::ST_INSERTED;
                n_state     = S_FINISH;
            end
            S_PICK: begin
                if (i_stat.pending_any) begin
                    o_cmd.pick   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = gbet_pkg::RD_PICK;
                    n_state      = S_MERGE;
                end else if (!r_phase) begin
                    o_cmd.save_with = 1'b1;
                    if (!i_stat.adj) begin
                        n_status = gbet_pkg::ST_NOT_EDGE;
                        n_state  = S_FINISH;
                    end else begin
                        o_cmd.init   = 1'b1;
                        o_cmd.init_b = 1'b1;
                        n_phase      = 1'b1;
                    end
                end else begin
                    n_status = i_stat.cnt_equal ? gbet_pkg::ST_NOT_BRIDGE
                                                : gbet_pkg::ST_BRIDGE;
                    n_state  = S_FINISH;
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state     = S_PICK;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_status    <= gbet_pkg::ST_INSERTED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/graph_bridge_edge_tester_top.sv]
// ----------------------------------------------------------------------------
// graph_bridge_edge_tester_top
// Undirected graph in a bit adjacency RAM; inserts edges and tests whether
// an edge is a bridge by comparing two reachability counts.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   --------------------------------------
//  in        i_in_valid / o_in_ready   i_mode, i_vertex_a, i_vertex_b
//  out       o_out_valid / i_out_ready o_status, o_reach_with_edge,
//                                      o_reach_without_edge
//  cfg       i_cfg_valid / o_cfg_ready i_cfg_data (vertex count)
//
//  A bad request goes straight to the result; an insert does two row read-
//  modify-writes. A query reads one adjacency row for each vertex reached in
//  each walk, then merges it into the visited set; the single RAM read port
//  paces the walk.
//  Reset clears the row valid bits at once, so the graph is empty with no
//  clearing pass. One request is in work at a time; the result register lets
//  the next request in while a result still waits for i_out_ready.
//
module graph_bridge_edge_tester_top #(
    parameter int MAX_NODES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [gbet_pkg::VTX_W-1:0] i_vertex_a,
    input  logic [gbet_pkg::VTX_W-1:0] i_vertex_b,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [gbet_pkg::ST_W-1:0]  o_status,
    output logic [gbet_pkg::CNT_W-1:0] o_reach_with_edge,
    output logic [gbet_pkg::CNT_W-1:0] o_reach_without_edge,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gbet_pkg::CNT_W-1:0] i_cfg_data
);

    gbet_pkg::t_cmd     cmd;
    gbet_pkg::t_dp_stat stat;

    // count register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    gbet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gbet_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_cfg_we             (i_cfg_valid),
        .i_cfg_data           (i_cfg_data),
        .i_mode               (i_mode),
        .i_vertex_a           (i_vertex_a),
        .i_vertex_b           (i_vertex_b),
        .o_status             (o_status),
        .o_reach_with_edge    (o_reach_with_edge),
        .o_reach_without_edge (o_reach_without_edge)
    );

    // a request in work blocks the next
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in work");

    // inserts and bad requests carry no counts
    a_counts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == gbet_pkg::ST_INSERTED ||
                         o_status == gbet_pkg::ST_RANGE))
        |-> (o_reach_with_edge == '0 && o_reach_without_edge == '0))
        else $error("counts set on insert or range result");

    // bridge verdict agrees with the counts it reports
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == gbet_pkg::ST_NOT_BRIDGE ||
                         o_status == gbet_pkg::ST_BRIDGE))
        |-> ((o_status == gbet_pkg::ST_NOT_BRIDGE) ==
             (o_reach_with_edge == o_reach_without_edge)))
        else $error("bridge status disagrees with counts");

    // a query walk always reaches at least its start vertex
    a_walk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == gbet_pkg::ST_NOT_EDGE ||
                         o_status == gbet_pkg::ST_NOT_BRIDGE ||
                         o_status == gbet_pkg::ST_BRIDGE))
        |-> (o_reach_with_edge != '0))
        else $error("query reports an empty walk");

endmodule

[dv/tb_graph_bridge_edge_tester_top.sv]
// ----------------------------------------------------------------------------
// tb_graph_bridge_edge_tester_top
// Self-checking bench for the bridge edge tester: a short table of directed
// requests and vertex count writes, then random phases of inserts and
// bridge queries at several vertex counts. Each result is compared with the
// bench's own model of the adjacency matrix and its reachability counts.
// ----------------------------------------------------------------------------
module tb_graph_bridge_edge_tester_top;

    localparam int VTX_W           = gbet_pkg::VTX_W;
    localparam int CNT_W           = gbet_pkg::CNT_W;
    localparam int ST_W            = gbet_pkg::ST_W;

    localparam int MAX_NODES       = 64;
    localparam int ITEMS_PER_PHASE = 53;
    localparam int HOLD_OFF        = 400;   // long receiver stall, in cycles
    localparam int DRAIN_CYCLES    = 300;   // above the slowest query
    localparam int LIMIT_CYCLES    = 1000000;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] reach_with_edge;
        logic [CNT_W-1:0] reach_without_edge;
    } t_bridge_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CNT_W-1:0] cfg_value;
        logic             mode;
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        logic             typed;    // want is fixed in the table
        t_bridge_result   want;
    } t_plan_row;

    localparam t_bridge_result NO_WANT = '{gbet_pkg::ST_INSERTED, 7'd0, 7'd0};
    localparam t_bridge_result RANGE_R = '{gbet_pkg::ST_RANGE, 7'd0, 7'd0};

    localparam int N_PLAN = 22;
    localparam t_plan_row PLAN [N_PLAN] = '{
        // empty graph, count zero after reset: everything out of range
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd0,  6'd0,  1'b1, RANGE_R},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd63, 6'd63, 1'b1, RANGE_R},
        // count above the row total saturates to 64
        '{ROW_CFG, 7'd127, MODE_INSERT, 6'd0,  6'd0,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd63, 6'd0,  1'b1, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd0,  6'd1,  1'b1, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd63, 6'd0,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd1,  6'd63, 1'b1, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd0,  6'd1,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd5,  6'd6,  1'b0, NO_WANT},
        // self loop
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd42, 6'd42, 1'b1, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd42, 6'd42, 1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd21, 6'd42, 1'b0, NO_WANT},
        // count lowered: stored edges to vertex 63 no longer followed
        '{ROW_CFG, 7'd2,   MODE_INSERT, 6'd0,  6'd0,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd2,  6'd0,  1'b1, RANGE_R},
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd1,  6'd2,  1'b1, RANGE_R},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd0,  6'd1,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd0,  6'd63, 1'b1, RANGE_R},
        '{ROW_CFG, 7'd1,   MODE_INSERT, 6'd0,  6'd0,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd0,  6'd0,  1'b0, NO_WANT},
        '{ROW_CFG, 7'd64,  MODE_INSERT, 6'd0,  6'd0,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_QUERY,  6'd63, 6'd1,  1'b0, NO_WANT},
        '{ROW_REQ, 7'd0,   MODE_INSERT, 6'd63, 6'd63, 1'b1, NO_WANT}
    };

    // vertex counts of the random phases, extremes included
    localparam int N_PHASES = 12;
    localparam int PHASE_COUNTS [N_PHASES] = '{5, 64, 8, 127, 0, 3, 16, 64, 1, 40, 2, 64};

    // ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = 1'b0;
    logic [VTX_W-1:0]     i_vertex_a = '0;
    logic [VTX_W-1:0]     i_vertex_b = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ST_W-1:0]      o_status;
    logic [CNT_W-1:0]     o_reach_with_edge;
    logic [CNT_W-1:0]     o_reach_without_edge;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CNT_W-1:0]     i_cfg_data = '0;

    // model state
    logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
    logic [CNT_W-1:0]     vertex_limit;
    logic [2*VTX_W-1:0]   links [$];          // inserted pairs, {a, b}
    t_bridge_result       awaited_outcomes [$];

    int  mismatches   = 0;
    int  results_seen = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    t_bridge_result head;

    graph_bridge_edge_tester_top #(
        .MAX_NODES(MAX_NODES)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_mode              (i_mode),
        .i_vertex_a          (i_vertex_a),
        .i_vertex_b          (i_vertex_b),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_reach_with_edge   (o_reach_with_edge),
        .o_reach_without_edge(o_reach_without_edge),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Effective vertex count: the register saturated to the row total.
    function automatic int live_vertices();
        return (vertex_limit > MAX_NODES) ? MAX_NODES : int'(vertex_limit);
    endfunction

    // Size of the set reachable from start, following only neighbours below n.
    // Grows the set to a fixed point; same count as a depth-first walk.
    function automatic logic [CNT_W-1:0] reach_count(input int start, input int n);
        logic [MAX_NODES-1:0] seen;
        logic [MAX_NODES-1:0] grow;
        logic [MAX_NODES-1:0] lane;
        int                   v;
        bit                   moved;
        lane  = (n >= MAX_NODES) ? '1 : ((MAX_NODES'(1) << n) - 1'b1);
        seen  = MAX_NODES'(1) << start;
        moved = 1'b1;
        while (moved) begin
            grow = seen;
            for (v = 0; v < MAX_NODES; v++) begin
                if (seen[v]) begin
                    grow |= adj_rows[v] & lane;
                end
            end
            moved = (grow != seen);
            seen  = grow;
        end
        return CNT_W'($countones(seen));
    endfunction

    // Applies one request to the model graph and gives its result.
    function automatic t_bridge_result judge_request(input logic m,
                                                     input logic [VTX_W-1:0] a,
                                                     input logic [VTX_W-1:0] b);
        t_bridge_result r;
        int             n;
        n = live_vertices();
        r = '{gbet_pkg::ST_INSERTED, '0, '0};
        if (a >= n || b >= n) begin
            r.status = gbet_pkg::ST_RANGE;
        end else if (m == MODE_INSERT) begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
        end else begin
            r.reach_with_edge = reach_count(a, n);
            if (!adj_rows[a][b]) begin
                r.status = gbet_pkg::ST_NOT_EDGE;
            end else begin
                // hide the edge both ways, walk from b, then put it back
                adj_rows[a][b] = 1'b0;
                adj_rows[b][a] = 1'b0;
                r.reach_without_edge = reach_count(b, n);
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                r.status = (r.reach_without_edge == r.reach_with_edge)
                           ? gbet_pkg::ST_NOT_BRIDGE : gbet_pkg::ST_BRIDGE;
            end
        end
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 10);
    endfunction

    // Offers one request and holds it until accepted; the model is advanced
    // at the acceptance edge so the expected results keep request order.
    task automatic send_request(input logic m, input logic [VTX_W-1:0] a,
                                input logic [VTX_W-1:0] b, input logic typed,
                                input t_bridge_result want);
        int             gap;
        t_bridge_result due;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_vertex_a <= a;
        i_vertex_b <= b;
        do @(posedge i_clk); while (!o_in_ready);
        due = judge_request(m, a, b);
        if (m == MODE_INSERT && due.status == gbet_pkg::ST_INSERTED) begin
            links.push_back({a, b});
        end
        awaited_outcomes.push_back(typed ? want : due);
    endtask

    // Vertex count writes only with the block idle: every result back first.
    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        i_in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        vertex_limit = value;
    endtask

    // Result checker: pre-edge values decide an accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
                $error("result with no request waiting: status %0d", o_status);
                mismatches++;
            end else begin
                head = awaited_outcomes.pop_front();
                if (o_status !== head.status) begin
                    $error("status: expected %0d, got %0d", head.status, o_status);
                    mismatches++;
                end
                if (o_reach_with_edge !== head.reach_with_edge) begin
                    $error("reach_with_edge: expected %0d, got %0d",
                           head.reach_with_edge, o_reach_with_edge);
                    mismatches++;
                end
                if (o_reach_without_edge !== head.reach_without_edge) begin
                    $error("reach_without_edge: expected %0d, got %0d",
                           head.reach_without_edge, o_reach_without_edge);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random stalls, and once a long hold-off so that the result
    // register stays full and the block has to stall its input side.
    initial begin : result_sink
        int quiet;
        int open_len;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && results_seen >= 120) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            quiet = rx_calm ? 0 : pick_gap();
            if (quiet > 0) begin
                i_out_ready <= 1'b0;
                repeat (quiet) @(posedge i_clk);
            end
            open_len = $urandom_range(12, 1);
            i_out_ready <= 1'b1;
            repeat (open_len) @(posedge i_clk);
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial begin : stimulus
        int               p;
        int               r;
        int               live;
        int               roll;
        logic             m;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [2*VTX_W-1:0] pair;

        foreach (adj_rows[i]) begin
            adj_rows[i] = '0;
        end
        vertex_limit = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (r = 0; r < N_PLAN; r++) begin
            if (PLAN[r].kind == ROW_CFG) begin
                write_vertex_count(PLAN[r].cfg_value);
            end else begin
                send_request(PLAN[r].mode, PLAN[r].va, PLAN[r].vb,
                             PLAN[r].typed, PLAN[r].want);
            end
        end

        // random part: mostly inserts and queries on stored edges, some noise
        for (p = 0; p < N_PHASES; p++) begin
            write_vertex_count(CNT_W'(PHASE_COUNTS[p]));
            tx_calm = (p % 5 == 2);
            rx_calm = (p % 5 == 2);
            live    = live_vertices();
            repeat (ITEMS_PER_PHASE) begin
                roll = $urandom_range(99, 0);
                if (live == 0 || roll < 6) begin
                    m = 1'($urandom_range(1, 0));
                    a = VTX_W'($urandom_range(63, 0));
                    b = VTX_W'($urandom_range(63, 0));
                end else if (roll < 56) begin
                    m = MODE_INSERT;
                    a = VTX_W'($urandom_range(live - 1, 0));
                    b = VTX_W'($urandom_range(live - 1, 0));
                end else begin
                    m = MODE_QUERY;
                    a = VTX_W'($urandom_range(live - 1, 0));
                    b = VTX_W'($urandom_range(live - 1, 0));
                    if (roll < 86 && links.size() > 0) begin
                        pair = links[$urandom_range(links.size() - 1, 0)];
                        if (pair[2*VTX_W-1:VTX_W] < live && pair[VTX_W-1:0] < live) begin
                            if ($urandom_range(1, 0)) begin
                                {a, b} = pair;
                            end else begin
                                {b, a} = pair;
                            end
                        end
                    end
                end
                send_request(m, a, b, 1'b0, NO_WANT);
            end
        end

        i_in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #(LIMIT_CYCLES * 8);
        $display("Mismatches found");
        $finish;
    end

endmodule
